// ===== design/square_matrix_multiply_core_macros.svh =====
// Assertion macros shared by the matrix multiply design.
`ifndef SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SMM_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("smm: assertion failed");

// Concurrent assertion on the standard clock and reset ports.
`define SMM_ASSERT(lbl, prop) `SMM_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== design/smm_pkg.sv =====
`timescale 1ns / 1ps

package smm_pkg;

  // One load: an element of A and the element of B at the same place.
  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] a_value;
    logic [31:0] b_value;
    logic        last;
  } smm_in_t;

  // One element of the product matrix.
  typedef struct packed {
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic [63:0] product_value;
    logic        out_last;
  } smm_out_t;

  // A classified load as passed from the front end to the compute engine.
  typedef struct packed {
    logic        wr;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] a_value;
    logic [31:0] b_value;
    logic        go;
  } smm_job_t;

endpackage

// ===== design/smm_ram.sv =====
`timescale 1ns / 1ps

module smm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/smm_front.sv =====
`timescale 1ns / 1ps

module smm_front #(
  parameter int unsigned DIM = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  smm_pkg::smm_in_t in_data_i,
  input  logic             push_i,
  output logic             full_o,
  output smm_pkg::smm_job_t job_o,
  output logic             job_valid_o,
  input  logic             job_ready_i
);

  import smm_pkg::*;

  logic     vld_q;
  smm_job_t job_q;
  smm_job_t job_d;
  logic     accept;

  // The holding register frees up whenever the queue takes its content.
  assign full_o = vld_q && !job_ready_i;
  assign accept = push_i && !full_o;

  // Classify the load: only in-range indices write the operand stores.
  always_comb begin
    job_d.wr      = (32'(in_data_i.row) < 32'(DIM)) && (32'(in_data_i.col) < 32'(DIM));
    job_d.row     = in_data_i.row;
    job_d.col     = in_data_i.col;
    job_d.a_value = in_data_i.a_value;
    job_d.b_value = in_data_i.b_value;
    job_d.go      = in_data_i.last;
  end

  // Valid flag of the holding register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (job_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // Payload of the holding register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_o       = job_q;
  assign job_valid_o = vld_q;

endmodule

// ===== design/smm_fifo.sv =====
`timescale 1ns / 1ps

module smm_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  smm_pkg::smm_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output smm_pkg::smm_job_t data_o,
  output logic              empty_o
);

  import smm_pkg::*;

  smm_job_t   mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/smm_back.sv =====
`timescale 1ns / 1ps
`include "square_matrix_multiply_core_macros.svh"

module smm_back #(
  parameter int unsigned DIM = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smm_pkg::smm_job_t job_i,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  output smm_pkg::smm_out_t out_data_o,
  output logic              empty_o,
  input  logic              pop_i
);

  import smm_pkg::*;

  localparam int unsigned AAW = $clog2(DIM * DIM);
  localparam int unsigned BAW = $clog2(DIM);
  localparam int unsigned CW  = $clog2(DIM + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } smm_state_e;

  smm_state_e state_q, state_d;

  logic [BAW-1:0] i_q, i_d;
  logic [BAW-1:0] k_q, k_d;
  logic [AAW-1:0] a_ptr_q, a_ptr_d;
  logic           busy_q;

  logic           issue;
  logic           row_start_ok;
  logic           k_last;
  logic           i_last;

  logic [AAW-1:0] a_waddr;
  logic [31:0]    a_rd;
  logic [31:0]    b_rd [DIM];

  logic           s1_vld_q, s1_first_q, s1_last_q;
  logic [BAW-1:0] s1_row_q;
  logic           s2_vld_q, s2_first_q, s2_last_q;
  logic [BAW-1:0] s2_row_q;

  logic [63:0]    prod_q  [DIM];
  logic [63:0]    acc_q   [DIM];
  logic [63:0]    acc_sum [DIM];
  logic [63:0]    buf_q   [DIM];
  logic [BAW-1:0] buf_row_q;
  logic [BAW-1:0] col_q;
  logic [CW-1:0]  cnt_q;

  logic           row_done;
  logic           do_pop;

  // Take the next queued load only between jobs, so loads never overtake a multiply.
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  // A new row starts once the previous row has landed and the result buffer is drained.
  assign row_start_ok = (cnt_q == '0) && !busy_q;
  assign issue        = (state_q == ST_RUN) && ((k_q != '0) || row_start_ok);
  assign k_last       = (k_q == BAW'(DIM - 1));
  assign i_last       = (i_q == BAW'(DIM - 1));

  // Sequencer: walk rows i, inner index k; one read per cycle unless a row start waits.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    k_d     = k_q;
    a_ptr_d = a_ptr_q;
    case (state_q)
      ST_IDLE: begin
        if (job_pop_o && job_i.go) begin
          state_d = ST_RUN;
          i_d     = '0;
          k_d     = '0;
          a_ptr_d = '0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          a_ptr_d = a_ptr_q + AAW'(1);
          if (k_last) begin
            k_d = '0;
            i_d = i_q + BAW'(1);
            if (i_last) begin
              state_d = ST_IDLE;
            end
          end else begin
            k_d = k_q + BAW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      a_ptr_q <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
      a_ptr_q <= a_ptr_d;
    end
  end

  // Operand store for A, row-major, so the row walk is a running pointer.
  assign a_waddr = AAW'(AAW'(job_i.row) * AAW'(DIM) + AAW'(job_i.col));

  smm_ram #(
    .WIDTH (32),
    .DEPTH (DIM * DIM)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (job_pop_o && job_i.wr),
    .waddr_i (a_waddr),
    .wdata_i (job_i.a_value),
    .re_i    (issue),
    .raddr_i (a_ptr_q),
    .rdata_o (a_rd)
  );

  // Operand store for B, one bank per column, so all lanes read row k together.
  for (genvar j = 0; j < DIM; j++) begin : g_lane
    smm_ram #(
      .WIDTH (32),
      .DEPTH (DIM)
    ) u_b_ram (
      .clk_i   (clk_i),
      .we_i    (job_pop_o && job_i.wr && (32'(job_i.col) == 32'(j))),
      .waddr_i (BAW'(job_i.row)),
      .wdata_i (job_i.b_value),
      .re_i    (issue),
      .raddr_i (k_q),
      .rdata_o (b_rd[j])
    );

    // Multiply stage, one multiplier per lane.
    always_ff @(posedge clk_i) begin
      if (s1_vld_q) begin
        prod_q[j] <= 64'(a_rd) * 64'(b_rd[j]);
      end
    end

    // Accumulate stage: the first inner step restarts the sum.
    assign acc_sum[j] = (s2_first_q ? 64'd0 : acc_q[j]) + prod_q[j];

    always_ff @(posedge clk_i) begin
      if (s2_vld_q) begin
        acc_q[j] <= acc_sum[j];
      end
    end
  end

  // Control tags that travel beside the read and multiply stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_row_q   <= '0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s2_row_q   <= '0;
    end else begin
      s1_vld_q   <= issue;
      s1_first_q <= (k_q == '0);
      s1_last_q  <= k_last;
      s1_row_q   <= i_q;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_row_q   <= s1_row_q;
    end
  end

  assign row_done = s2_vld_q && s2_last_q;
  assign do_pop   = pop_i && (cnt_q != '0);

  // Row in flight, result buffer fill level and column of the head element.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      col_q  <= '0;
    end else begin
      if (issue && (k_q == '0)) begin
        busy_q <= 1'b1;
      end else if (row_done) begin
        busy_q <= 1'b0;
      end
      if (row_done) begin
        cnt_q <= CW'(DIM);
        col_q <= '0;
      end else if (do_pop) begin
        cnt_q <= cnt_q - CW'(1);
        col_q <= col_q + BAW'(1);
      end
    end
  end

  // Result buffer: loaded with a finished row, shifted toward the head on each transfer.
  always_ff @(posedge clk_i) begin
    if (row_done) begin
      buf_row_q <= s2_row_q;
      for (int j = 0; j < DIM; j++) begin
        buf_q[j] <= acc_sum[j];
      end
    end else if (do_pop) begin
      for (int j = 0; j < DIM - 1; j++) begin
        buf_q[j] <= buf_q[j + 1];
      end
    end
  end

  // Head of the result buffer drives the output.
  assign empty_o                  = (cnt_q == '0);
  assign out_data_o.out_row       = 3'(buf_row_q);
  assign out_data_o.out_col       = 3'(col_q);
  assign out_data_o.product_value = buf_q[0];
  assign out_data_o.out_last      = (buf_row_q == BAW'(DIM - 1)) && (col_q == BAW'(DIM - 1));

  // A row starts only with the buffer drained and no other row in flight.
  `SMM_ASSERT(a_row_start_clear, issue && (k_q == '0) |-> (cnt_q == '0) && !busy_q)
  // A finished row never lands on top of unsent results.
  `SMM_ASSERT(a_load_on_empty, row_done |-> (cnt_q == '0))
  // Nothing moves through the pipeline outside a row in flight.
  `SMM_ASSERT(a_pipe_idle, !busy_q |-> !s1_vld_q && !s2_vld_q)

endmodule

// ===== design/square_matrix_multiply_core.sv =====
`timescale 1ns / 1ps
// Loads are taken one per cycle while full is low; a multiply runs DIM rows, each DIM store reads
// wide followed by a drain of the DIM-entry result buffer.
// Throughput is set by the single read port of the A store and the one-row result buffer.
// Reset clears all control state; the operand stores hold undefined data until written.
module square_matrix_multiply_core #(
  parameter int unsigned DIM = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smm_pkg::smm_in_t  in_data_i,
  input  logic              push,
  output logic              full,
  output smm_pkg::smm_out_t out_data_o,
  output logic              empty,
  input  logic              pop
);

  import smm_pkg::*;

  smm_job_t front_job;
  logic     front_valid;
  logic     q_full;
  smm_job_t q_job;
  logic     q_empty;
  logic     back_pop;

  // Front end: accept and classify loads.
  smm_front #(
    .DIM (DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .push_i      (push),
    .full_o      (full),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (!q_full)
  );

  // Short queue between the front end and the compute engine.
  smm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_job),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .data_o  (q_job),
    .empty_o (q_empty)
  );

  // Compute engine: operand stores, multiply lanes and result buffer.
  smm_back #(
    .DIM (DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_valid_i (!q_empty),
    .job_pop_o   (back_pop),
    .out_data_o  (out_data_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule
